@@ src/sksok_pkg.sv @@
// shared types, constants and helper functions for the second-order scalar kalman core
// used by the divider, the multiplier and the top level; depends on nothing
package sksok_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int DIV_W   = 96;
	localparam int DIV_LW  = 7;
	localparam int DEN_W   = 41;
	localparam int MUL_AW  = 64;
	localparam int MUL_KW  = 33;
	localparam int ADDR_W  = 5;

	localparam logic [63:0] PI_SQ_Q32 = 64'd42389628127;
	localparam logic [62:0] QUO_CAP   = 63'h4000_0000_0000_0000;
	localparam logic [39:0] VAR_MAX   = 40'hFF_FFFF_FFFF;

	localparam logic [31:0] RST_NOISE       = 32'd65536;
	localparam logic [31:0] RST_PROC_NOISE  = 32'd655360000;
	localparam logic [31:0] RST_PERIOD      = 32'd4294967;

	localparam logic [2:0] REG_NOISE_VALUE = 3'd0;
	localparam logic [2:0] REG_NOISE_RATE  = 3'd1;
	localparam logic [2:0] REG_NOISE_ACCEL = 3'd2;
	localparam logic [2:0] REG_PROC_NOISE  = 3'd3;
	localparam logic [2:0] REG_PERIOD      = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_UPD,
		ST_FINAL
	} state_t;

	typedef enum logic [4:0] {
		OP_KV, OP_KR, OP_KA, OP_Q1, OP_Q2A, OP_Q2B,
		OP_MV, OP_MR, OP_MA,
		OP_PV, OP_PR, OP_PA, OP_T2, OP_T4,
		OP_XR, OP_XA, OP_RA, OP_VR, OP_VA4, OP_VA2
	} op_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DIV_LW-1:0] len;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_KW-1:0] k;
	} mul_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [MUL_AW-1:0] res;
	} mul_rsp_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [39:0] satv(input logic [41:0] v);
		return (v > {2'b00, VAR_MAX}) ? VAR_MAX : v[39:0];
	endfunction

endpackage

@@ src/sksok_div.sv @@
// restoring divider, one quotient bit per cycle, numerator left aligned with a bit count
// depends on sksok_pkg
module sksok_div
	import sksok_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DIV_LW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] trial;
	logic           ge;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_LW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_last_bit_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && cnt_q == DIV_LW'(1) |=> done_q && !busy_q)
		else $error("divider did not finish after its last bit");

endmodule

@@ src/sksok_mul.sv @@
// fractional multiplier floor(a*k/2^32), k at most 2^32, two 32x32 partial products
// depends on sksok_pkg
module sksok_mul
	import sksok_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_KW-1:0] k_q;
	logic [63:0]       pp_q;
	logic [31:0]       lo_q;
	logic [MUL_AW-1:0] res_q;
	logic [1:0]        ph_q;
	logic              busy_q;
	logic              done_q;

	logic [31:0] mul_a;

	assign mul_a = (ph_q == 2'd0) ? a_q[31:0] : a_q[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			k_q <= req.k;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: pp_q <= mul_a * k_q[31:0];
				2'd1: begin
					lo_q <= pp_q[63:32];
					pp_q <= mul_a * k_q[31:0];
				end
				default: begin
					// k of exactly one keeps a unchanged
					res_q <= k_q[32] ? a_q : pp_q + {32'b0, lo_q};
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.start && !busy_q |-> ##4 done_q)
		else $error("multiplier latency broken");

endmodule

@@ src/scalar_kalman_second_order_core.sv @@
// top level of the decoupled value/rate/acceleration kalman tracker: apb registers,
// sequencer and datapath around one shared divider and one shared multiplier
// depends on sksok_pkg, sksok_div, sksok_mul
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    func, measured
// out      output     out_valid/out_ready  est_value, est_rate, est_accel
// apb      input      psel/penable/pready  paddr, pwdata, prdata
//
// a filter transaction runs six divisions at one quotient bit per cycle (72 bits per gain,
// 65, 66 and 95 for the quotients), which dominate it, and 14 multiplies; a reinitialize
// transaction runs neither and goes straight to the output register
// one transaction is in flight at a time; in_ready is high only while the sequencer is idle
// a finished result waits in the output register while the next transaction is taken
// after reset the estimates and variances hold their initial values
module scalar_kalman_second_order_core
	import sksok_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] measured,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] est_value,
	output logic signed [31:0] est_rate,
	output logic signed [31:0] est_accel,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [31:0] ValInit =
		32'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [39:0] VarInit =
		40'((PI_SQ_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	// configuration registers
	logic [31:0] noise_value_q, noise_rate_q, noise_accel_q, proc_noise_q, period_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_value_q <= RST_NOISE;
			noise_rate_q  <= RST_NOISE;
			noise_accel_q <= RST_NOISE;
			proc_noise_q  <= RST_PROC_NOISE;
			period_q      <= RST_PERIOD;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_NOISE_VALUE: noise_value_q <= pwdata;
				REG_NOISE_RATE:  noise_rate_q  <= pwdata;
				REG_NOISE_ACCEL: noise_accel_q <= pwdata;
				REG_PROC_NOISE:  proc_noise_q  <= pwdata;
				REG_PERIOD:      period_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_NOISE_VALUE: prdata = noise_value_q;
			REG_NOISE_RATE:  prdata = noise_rate_q;
			REG_NOISE_ACCEL: prdata = noise_accel_q;
			REG_PROC_NOISE:  prdata = proc_noise_q;
			REG_PERIOD:      prdata = period_q;
			default:         prdata = '0;
		endcase
	end

	// filter state
	logic [31:0] value_est_q, rate_est_q, accel_est_q;
	logic [39:0] var_value_q, var_rate_q, var_accel_q;

	// per transaction temporaries
	logic        init_q, neg_q;
	logic [32:0] m_q;
	logic [32:0] kv_q, kr_q, ka_q;
	logic [62:0] q1_q, q2_q;
	logic [32:0] mv_q;
	logic [62:0] mr_q, ma_q;
	logic [31:0] x11_q, r11_q, a11_q;
	logic [39:0] pv_q, pr_q, pa_q, vr_q, va4_q, va2_q;
	logic [31:0] t2_q, t4_q, xr_q, xa_q, ra_q;

	logic [31:0] out_value_q, out_rate_q, out_accel_q;
	logic        out_valid_q;

	state_t state_q, state_d;
	op_t    op_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic is_div, unit_done, last_mul, accept, fin_go, issue_go;
	logic [31:0] tp;

	assign tp        = (period_q == 32'd0) ? 32'd1 : period_q;
	assign accept    = in_valid && in_ready;
	assign unit_done = is_div ? div_rsp.done : mul_rsp.done;
	assign fin_go    = (state_q == ST_FINAL) && (!out_valid_q || out_ready);
	assign last_mul  = (op_q == OP_VA2);
	assign issue_go  = (state_q == ST_ISSUE);

	always_comb begin
		case (op_q) inside
			OP_KV, OP_KR, OP_KA, OP_Q1, OP_Q2A, OP_Q2B: is_div = 1'b1;
			default: is_div = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = func ? ST_FINAL : ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (unit_done) begin
					if (op_q == OP_MA) begin
						state_d = ST_UPD;
					end else if (last_mul) begin
						state_d = ST_FINAL;
					end else begin
						state_d = ST_ISSUE;
					end
				end
			end
			ST_UPD: state_d = ST_ISSUE;
			ST_FINAL: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_KV;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= OP_KV;
			end else if (state_q == ST_WAIT && unit_done && !last_mul) begin
				op_q <= op_t'(5'(op_q) + 5'd1);
			end
		end
	end

	// operand selection for the shared units
	logic [DEN_W-1:0] gden;
	logic [39:0]      gvar;
	logic [31:0]      gnoise;
	logic [31:0]      r11_mag, a11_mag;

	assign r11_mag = r11_q[31] ? 32'(-r11_q) : r11_q;
	assign a11_mag = a11_q[31] ? 32'(-a11_q) : a11_q;

	always_comb begin
		div_req.start = issue_go && is_div;
		mul_req.start = issue_go && !is_div;

		unique case (op_q)
			OP_KR:   begin gvar = var_rate_q;  gnoise = noise_rate_q;  end
			OP_KA:   begin gvar = var_accel_q; gnoise = noise_accel_q; end
			default: begin gvar = var_value_q; gnoise = noise_value_q; end
		endcase
		gden = {1'b0, gvar} + {9'b0, gnoise};

		div_req.num = {m_q, 63'b0};
		div_req.len = DIV_LW'(65);
		div_req.den = {9'b0, tp};
		unique case (op_q)
			OP_KV, OP_KR, OP_KA: begin
				div_req.num = {gvar, 56'b0};
				div_req.len = DIV_LW'(72);
				div_req.den = gden;
			end
			OP_Q2A:  div_req.len = DIV_LW'(66);
			OP_Q2B: begin
				div_req.num = {q2_q, 33'b0};
				div_req.len = DIV_LW'(95);
			end
			default: ;
		endcase

		mul_req.a = {32'b0, tp};
		mul_req.k = {1'b0, tp};
		unique case (op_q)
			OP_MV:  begin mul_req.a = {31'b0, m_q};          mul_req.k = kv_q; end
			OP_MR:  begin mul_req.a = {1'b0, q1_q};          mul_req.k = kr_q; end
			OP_MA:  begin mul_req.a = {1'b0, q2_q};          mul_req.k = ka_q; end
			OP_PV:  begin mul_req.a = {24'b0, var_value_q};
				mul_req.k = 33'h1_0000_0000 - kv_q; end
			OP_PR:  begin mul_req.a = {24'b0, var_rate_q};
				mul_req.k = 33'h1_0000_0000 - kr_q; end
			OP_PA:  begin mul_req.a = {24'b0, var_accel_q};
				mul_req.k = 33'h1_0000_0000 - ka_q; end
			OP_T4:  begin mul_req.a = {32'b0, t2_q};         mul_req.k = {1'b0, t2_q}; end
			OP_XR:  begin mul_req.a = {32'b0, r11_mag};      mul_req.k = {1'b0, tp}; end
			OP_XA:  begin mul_req.a = {32'b0, a11_mag};      mul_req.k = {1'b0, t2_q}; end
			OP_RA:  begin mul_req.a = {32'b0, a11_mag};      mul_req.k = {1'b0, tp}; end
			OP_VR:  begin mul_req.a = {24'b0, pr_q};         mul_req.k = {1'b0, t2_q}; end
			OP_VA4: begin mul_req.a = {24'b0, pa_q};         mul_req.k = {1'b0, t4_q}; end
			OP_VA2: begin mul_req.a = {24'b0, pa_q};         mul_req.k = {1'b0, t2_q}; end
			default: ;
		endcase
	end

	sksok_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sksok_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// datapath arithmetic
	logic signed [32:0] d_in;
	logic [62:0]        quo_cap;
	logic [32:0]        gain_res;
	logic signed [65:0] mv_s, mr_s, ma_s, x11_sum, r11_sum, a11_sum;
	logic signed [65:0] xr_s, xa_s, ra_s, val_sum, rate_sum;
	logic [41:0]        vv_sum, vr_sum, va_sum;

	assign d_in     = $signed({measured[31], measured}) -
		$signed({value_est_q[31], value_est_q});
	assign quo_cap  = (div_rsp.quo > {33'b0, QUO_CAP}) ? QUO_CAP : div_rsp.quo[62:0];
	// zero denominator means no update
	assign gain_res = (gden == '0) ? 33'b0 : div_rsp.quo[32:0];

	assign mv_s = $signed({33'b0, mv_q});
	assign mr_s = $signed({3'b0, mr_q});
	assign ma_s = $signed({3'b0, ma_q});
	assign x11_sum = $signed({{34{value_est_q[31]}}, value_est_q}) + (neg_q ? -mv_s : mv_s);
	assign r11_sum = $signed({{34{rate_est_q[31]}}, rate_est_q}) + (neg_q ? -mr_s : mr_s);
	assign a11_sum = $signed({{34{accel_est_q[31]}}, accel_est_q}) + (neg_q ? -ma_s : ma_s);

	assign xr_s = $signed({34'b0, xr_q});
	assign xa_s = $signed({35'b0, xa_q[31:1]});
	assign ra_s = $signed({34'b0, ra_q});
	assign val_sum = $signed({{34{x11_q[31]}}, x11_q}) + (r11_q[31] ? -xr_s : xr_s) +
		(a11_q[31] ? -xa_s : xa_s);
	assign rate_sum = $signed({{34{r11_q[31]}}, r11_q}) + (a11_q[31] ? -ra_s : ra_s);
	assign vv_sum = {2'b0, pv_q} + {2'b0, vr_q} + {4'b0, va4_q[39:2]};
	assign vr_sum = {2'b0, pr_q} + {2'b0, va2_q};
	assign va_sum = {2'b0, pa_q} + {10'b0, proc_noise_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			init_q <= func;
			neg_q  <= d_in[32];
			m_q    <= d_in[32] ? 33'(-d_in) : 33'(d_in);
		end
		if (state_q == ST_WAIT && div_rsp.done) begin
			unique case (op_q)
				OP_KV:   kv_q <= gain_res;
				OP_KR:   kr_q <= gain_res;
				OP_KA:   ka_q <= gain_res;
				OP_Q1:   q1_q <= quo_cap;
				OP_Q2A:  q2_q <= quo_cap;
				OP_Q2B:  q2_q <= quo_cap;
				default: ;
			endcase
		end
		if (state_q == ST_WAIT && mul_rsp.done) begin
			unique case (op_q)
				OP_MV:   mv_q  <= mul_rsp.res[32:0];
				OP_MR:   mr_q  <= mul_rsp.res[62:0];
				OP_MA:   ma_q  <= mul_rsp.res[62:0];
				OP_PV:   pv_q  <= mul_rsp.res[39:0];
				OP_PR:   pr_q  <= mul_rsp.res[39:0];
				OP_PA:   pa_q  <= mul_rsp.res[39:0];
				OP_T2:   t2_q  <= mul_rsp.res[31:0];
				OP_T4:   t4_q  <= mul_rsp.res[31:0];
				OP_XR:   xr_q  <= mul_rsp.res[31:0];
				OP_XA:   xa_q  <= mul_rsp.res[31:0];
				OP_RA:   ra_q  <= mul_rsp.res[31:0];
				OP_VR:   vr_q  <= mul_rsp.res[39:0];
				OP_VA4:  va4_q <= mul_rsp.res[39:0];
				OP_VA2:  va2_q <= mul_rsp.res[39:0];
				default: ;
			endcase
		end
		if (state_q == ST_UPD) begin
			x11_q <= sat32(x11_sum);
			r11_q <= sat32(r11_sum);
			a11_q <= sat32(a11_sum);
		end
	end

	// state update and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_est_q <= ValInit;
			rate_est_q  <= ValInit;
			accel_est_q <= ValInit;
			var_value_q <= VarInit;
			var_rate_q  <= VarInit;
			var_accel_q <= VarInit;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (init_q) begin
					value_est_q <= ValInit;
					rate_est_q  <= ValInit;
					accel_est_q <= ValInit;
					var_value_q <= VarInit;
					var_rate_q  <= VarInit;
					var_accel_q <= VarInit;
				end else begin
					value_est_q <= sat32(val_sum);
					rate_est_q  <= sat32(rate_sum);
					accel_est_q <= a11_q;
					var_value_q <= satv(vv_sum);
					var_rate_q  <= satv(vr_sum);
					var_accel_q <= satv(va_sum);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_value_q <= init_q ? ValInit : sat32(val_sum);
			out_rate_q  <= init_q ? ValInit : sat32(rate_sum);
			out_accel_q <= init_q ? ValInit : a11_q;
		end
	end

	assign out_valid = out_valid_q;
	assign est_value = out_value_q;
	assign est_rate  = out_rate_q;
	assign est_accel = out_accel_q;

	a_one_unit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_rsp.busy && mul_rsp.busy))
		else $error("divider and multiplier busy together");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(div_rsp.done || mul_rsp.done) |-> state_q == ST_WAIT)
		else $error("unit finished outside the wait state");

	a_final_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not loaded into the output register");

	a_filter_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !func |=> state_q == ST_ISSUE && op_q == OP_KV)
		else $error("filter transaction did not start at the first gain");

endmodule
